[sv/vector_matrix_multiply_assert.svh]
// Assertion macros shared by the checkers of this block.
// Each expects clk and rst_n in the scope where it is used.
`ifndef VECTOR_MATRIX_MULTIPLY_ASSERT_SVH
`define VECTOR_MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define VMM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmm check failed");

// Next-cycle implication.
`define VMM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmm check failed");

`endif

[sv/vmm_pkg.sv]
package vmm_pkg;

    localparam int ACC_W = 38;  // Q8.30 accumulator
    localparam int VAL_W = 16;  // Q1.15 input value
    localparam int LEN_W = 7;   // length registers and element counter
    localparam int IDX_W = 6;   // row, column and result index

    localparam logic [LEN_W-1:0] CNT_MAX = 7'd127;

    typedef logic signed [ACC_W-1:0] acc_t;

endpackage

[sv/vmm_ram.sv]
module vmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/vmm_cell.sv]
// One accumulator of the column ring.
module vmm_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  vmm_pkg::acc_t d,
    output vmm_pkg::acc_t q
);
    import vmm_pkg::*;

    acc_t acc_reg;
    acc_t acc_next;

    always_comb
    begin
        acc_next = shift ? d : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign q = acc_reg;

endmodule

[sv/vmm_mac.sv]
// Registered signed product, sign-extended to accumulator width.
module vmm_mac #(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [W-1:0] a,
    input  logic signed [W-1:0] b,
    output logic                prod_valid,
    output vmm_pkg::acc_t       prod
);
    import vmm_pkg::*;

    logic signed [2*W-1:0] p;
    acc_t                  prod_reg;
    acc_t                  prod_next;
    logic                  valid_reg;

    always_comb
    begin
        p         = a * b;
        prod_next = acc_t'(p);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod_valid = valid_reg;
    assign prod       = prod_reg;

endmodule

[sv/vector_matrix_multiply.sv]
// Channel      Direction  Handshake                         Payload
// config       in/out     psel, penable, pwrite, pready     paddr, pwdata, prdata
// command      in         start & !busy                     cmd, row, col, value, last
// result       out        result_valid                      out_index, out_value,
//                                                           size_mismatch, last_result
//
// A weight write leaves busy low. A vector element inside in_length holds busy while one weight
// read per column is issued into the single multiplier, the read and multiply stages drain and
// the sequencer sees them empty. An element beyond in_length holds busy through the drain state
// or, when it is the last, goes straight to output. Output shifts the whole ring out while busy,
// emitting the first out_length columns. Reset clears accumulators, counter and sequencer and
// sets both lengths to 16; the weight RAM has no reset and no clearing pass. Results cannot be
// stalled by the receiver.
module vector_matrix_multiply #(
    parameter int MAX_IN_LEN  = 16,
    parameter int MAX_OUT_LEN = 16,
    parameter int DATA_WIDTH  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              cmd,
    input  logic [vmm_pkg::IDX_W-1:0]         row,
    input  logic [vmm_pkg::IDX_W-1:0]         col,
    input  logic signed [vmm_pkg::VAL_W-1:0]  value,
    input  logic                              last,
    // result channel
    output logic                              result_valid,
    output logic [vmm_pkg::IDX_W-1:0]         out_index,
    output logic signed [vmm_pkg::ACC_W-1:0]  out_value,
    output logic                              size_mismatch,
    output logic                              last_result
);
    import vmm_pkg::*;

    // effective value width: narrower data widths keep the low bits, sign-extended
    localparam int EW    = DATA_WIDTH < VAL_W ? DATA_WIDTH : VAL_W;
    localparam int RW    = MAX_IN_LEN > 1 ? $clog2(MAX_IN_LEN) : 1;
    localparam int CW    = MAX_OUT_LEN > 1 ? $clog2(MAX_OUT_LEN) : 1;
    localparam int DEPTH = MAX_IN_LEN * MAX_OUT_LEN;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    // register index, taken from paddr[2]
    localparam logic REG_IN_LEN  = 1'b0;
    localparam logic REG_OUT_LEN = 1'b1;

    localparam logic CMD_WEIGHT = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MAC   = 4'b0010,  // issue one weight read per column
        ST_DRAIN = 4'b0100,  // let the read and multiply stages empty
        ST_OUT   = 4'b1000   // shift the ring out through the result port
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] in_len_reg, in_len_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [RW-1:0]    row_reg, row_next;
    logic signed [EW-1:0] val_reg, val_next;
    logic             last_reg, last_next;
    logic             mism_reg, mism_next;
    logic             rd_vld_reg;

    logic             cfg_wr;
    logic             accept;
    logic             weight_wr;
    logic             do_acc;
    logic [LEN_W-1:0] eff_in;
    logic [LEN_W-1:0] eff_out;
    logic [LEN_W-1:0] cnt_inc;
    logic [LEN_W-1:0] col_ext;
    logic [31:0]      wr_lin;
    logic [31:0]      rd_lin;
    logic             rd_en;
    logic [EW-1:0]    rdata;
    logic             prod_valid;
    acc_t             prod;
    acc_t             tail;
    logic             ring_shift;
    acc_t             cell_q [MAX_OUT_LEN];

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        in_len_next  = in_len_reg;
        out_len_next = out_len_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_IN_LEN:  in_len_next  = pwdata[LEN_W-1:0];
                REG_OUT_LEN: out_len_next = pwdata[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IN_LEN:  prdata = 32'(in_len_reg);
            REG_OUT_LEN: prdata = 32'(out_len_reg);
            default:     prdata = '0;
        endcase
    end

    // lengths above the array size are limited to it
    assign eff_in  = (in_len_reg > LEN_W'(MAX_IN_LEN)) ? LEN_W'(MAX_IN_LEN) : in_len_reg;
    assign eff_out = (out_len_reg > LEN_W'(MAX_OUT_LEN)) ? LEN_W'(MAX_OUT_LEN) : out_len_reg;

    // ---------------- command intake ----------------
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start & ~busy;

    // out-of-range weight writes are dropped
    assign weight_wr = accept && (cmd == CMD_WEIGHT)
                       && ({1'b0, row} < LEN_W'(MAX_IN_LEN))
                       && ({1'b0, col} < LEN_W'(MAX_OUT_LEN));
    assign wr_lin = 32'(row) * 32'(MAX_OUT_LEN) + 32'(col);
    assign rd_lin = 32'(row_reg) * 32'(MAX_OUT_LEN) + 32'(col_reg);

    // element position before this one is counted; counter saturates
    assign do_acc  = (cnt_reg < eff_in);
    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + LEN_W'(1);

    assign rd_en = (state_reg == ST_MAC);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        mism_next  = mism_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd != CMD_WEIGHT))
                begin
                    row_next  = cnt_reg[RW-1:0];
                    val_next  = value[EW-1:0];
                    last_next = last;
                    mism_next = (cnt_inc != in_len_reg);
                    col_next  = '0;
                    // the element count restarts once the last element is in
                    cnt_next  = last ? '0 : cnt_inc;
                    if (do_acc)
                    begin
                        state_next = ST_MAC;
                    end
                    else if (last)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_MAC:
            begin
                if (col_reg == CW'(MAX_OUT_LEN - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !prod_valid)
                begin
                    col_next   = '0;
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (col_reg == CW'(MAX_OUT_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            in_len_reg  <= LEN_W'(16);
            out_len_reg <= LEN_W'(16);
            cnt_reg     <= '0;
            col_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_len_reg  <= in_len_next;
            out_len_reg <= out_len_next;
            cnt_reg     <= cnt_next;
            col_reg     <= col_next;
            rd_vld_reg  <= rd_en;
            last_reg    <= last_next;
        end
    end

    // per-element payload
    always_ff @(posedge clk)
    begin
        row_reg  <= row_next;
        val_reg  <= val_next;
        mism_reg <= mism_next;
    end

    // ---------------- weight store and multiplier ----------------
    vmm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_wram (
        .clk   (clk),
        .we    (weight_wr),
        .waddr (wr_lin[AW-1:0]),
        .wdata (value[EW-1:0]),
        .re    (rd_en),
        .raddr (rd_lin[AW-1:0]),
        .rdata (rdata)
    );

    vmm_mac #(
        .W (EW)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (rd_vld_reg),
        .a          (val_reg),
        .b          (rdata),
        .prod_valid (prod_valid),
        .prod       (prod)
    );

    // ---------------- column ring ----------------
    // Cell 0 always holds the column that the next product belongs to. Each product is
    // added to it and the sum re-enters at the tail, so after MAX_OUT_LEN products the
    // ring is back in column order. During output the tail takes zero, clearing the ring.
    assign ring_shift = prod_valid || (state_reg == ST_OUT);
    assign tail       = prod_valid ? cell_q[0] + prod : '0;

    for (genvar k = 0; k < MAX_OUT_LEN; k++)
    begin : g_cell
        acc_t d;
        if (k == MAX_OUT_LEN - 1)
        begin : g_tail
            assign d = tail;
        end
        else
        begin : g_link
            assign d = cell_q[k+1];
        end
        vmm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ring_shift),
            .d     (d),
            .q     (cell_q[k])
        );
    end

    // ---------------- results ----------------
    assign col_ext       = LEN_W'(col_reg);
    assign result_valid  = (state_reg == ST_OUT) && (col_ext < eff_out);
    assign out_index     = IDX_W'(col_reg);
    assign out_value     = cell_q[0];
    assign size_mismatch = mism_reg;
    assign last_result   = (col_ext + LEN_W'(1)) == eff_out;

endmodule

[sv/vmm_checker.sv]
`include "vector_matrix_multiply_assert.svh"

module vmm_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic result_valid,
    input logic size_mismatch,
    input logic last_result
);

    // results of one vector come out back to back, with one flag for all of them
    `VMM_ASSERT_NXT(a_results_contiguous, result_valid && !last_result, result_valid)
    `VMM_ASSERT_NXT(a_flag_steady, result_valid && !last_result, $stable(size_mismatch))
    // nothing follows the final result in the next cycle
    `VMM_ASSERT_NXT(a_gap_after_last, result_valid && last_result, !result_valid)
    // a vector element always occupies the block; a weight write never does
    `VMM_ASSERT_NXT(a_element_busy, start && !busy && cmd, busy)
    `VMM_ASSERT_NXT(a_weight_free, start && !busy && !cmd, !busy)

endmodule

bind vector_matrix_multiply vmm_checker u_vmm_checker (.*);
